// ----- sv/multichannel_pulse_tachometer_defines.svh -----
// assertion macros for the multichannel pulse tachometer checker
// expects clk and rst_n in the scope of each use
`ifndef MULTICHANNEL_PULSE_TACHOMETER_DEFINES_SVH
`define MULTICHANNEL_PULSE_TACHOMETER_DEFINES_SVH
// checked only while out of reset
`define MPT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define MPT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- sv/mpt_pkg.sv -----
// shared types, constants and codes of the multichannel pulse tachometer
// no dependencies
package mpt_pkg;
  localparam int CHANNELS   = 4;
  localparam int RING_DEPTH = 8;
  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RIDX_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int NUM_W      = 32;
  localparam int DEN_W      = 23;
  localparam int DIV_CNT_W  = $clog2(NUM_W);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [NUM_W-1:0] US_PER_MINUTE = 32'd60000000;

  localparam logic [1:0] MODE_EDGE   = 2'd0;
  localparam logic [1:0] MODE_TICK   = 2'd1;
  localparam logic [1:0] MODE_REPORT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLE_PAIRS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTLIER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK       = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  channel;
    logic [31:0] timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  report_channel;
    logic [15:0] speed_rpm;
    logic        last;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE,
    S_EDGE_CHK, S_EDGE_MUL, S_EDGE_GO, S_EDGE_WAIT, S_EDGE_STORE,
    S_TICK_MUL1, S_TICK_MUL2, S_TICK_GO, S_TICK_WAIT, S_TICK_STORE,
    S_RPT_START, S_RANK_LOAD, S_RANK_CMP, S_RANK_PICK,
    S_RPT_MUL, S_RPT_GO, S_RPT_WAIT, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_EDGE_COMMIT, DP_EDGE_MUL, DP_DIV_START, DP_EDGE_STORE,
    DP_TICK_MUL1, DP_TICK_MUL2, DP_TICK_STORE, DP_RANK_LOAD, DP_RANK_CMP,
    DP_RANK_PICK, DP_RPT_MUL, DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [CH_W-1:0]   ch;
    logic [RIDX_W-1:0] idx;
    logic [RIDX_W-1:0] cand;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0]      mode;
    logic [CH_W-1:0] chan;
    logic            chan_ok;
    logic            edge_ok;
    logic            win_ok;
    logic            rank_hit;
    logic            div_done;
    logic            out_free;
  } dp_status_t;
endpackage

// ----- sv/mpt_div.sv -----
// iterative restoring divider, one quotient bit per cycle
// depends on mpt_pkg; a zero divisor gives an all-ones quotient
module mpt_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [mpt_pkg::NUM_W-1:0] num,
  input  logic [mpt_pkg::DEN_W-1:0] den,
  output logic [mpt_pkg::NUM_W-1:0] quo,
  output logic                      done
);
  import mpt_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0]     rem_r;
  logic [DEN_W-1:0]     den_r;
  logic [NUM_W-1:0]     quo_r;
  logic [DEN_W:0]       sh;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign sh   = {rem_r, quo_r[NUM_W-1]};
  assign ge   = sh >= {1'b0, den_r};
  assign diff = sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      den_r <= den;
      quo_r <= num;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_r <= {quo_r[NUM_W-2:0], ge};
    end
  end

  assign quo  = quo_r;
  assign done = done_r;
endmodule

// ----- sv/mpt_dp.sv -----
// datapath: configuration, per-channel state, period rings, multiplies and output register
// depends on mpt_pkg and mpt_div
module mpt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpt_pkg::in_item_t             in_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output mpt_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  mpt_pkg::ctrl_cmd_t            cmd,
  output mpt_pkg::dp_status_t           status
);
  import mpt_pkg::*;

  logic [15:0] min_period_r;
  logic [6:0]  pole_r;
  logic [15:0] outlier_r;
  logic [15:0] min_valid_r;
  logic [9:0]  windows_r;
  logic [2:0]  rank_r;

  in_item_t          item_r;
  logic [31:0]       last_edge_r [CHANNELS];
  logic [RIDX_W-1:0] ring_r      [CHANNELS];
  logic [15:0]       count_r     [CHANNELS];
  logic [23:0]       win_r       [CHANNELS];
  logic [15:0]       store_r     [CHANNELS][RING_DEPTH];

  logic [15:0]      period_r;
  logic [25:0]      prod_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] den_r;
  logic [15:0]      cand_r;
  logic [CNT_W-1:0] less_r;
  logic [15:0]      sel_r;
  out_item_t        out_r;
  logic             out_valid_r;

  logic             div_start;
  logic [NUM_W-1:0] quo;
  logic             div_done;

  logic [31:0]      delta;
  logic [15:0]      period_c;
  logic [23:0]      rpm24;
  logic [15:0]      rpm16;
  logic [23:0]      diff;
  logic             store_ok;
  logic             win_ok;
  logic [15:0]      rd;
  logic [CNT_W-1:0] rank_eff;
  logic             out_free;

  assign delta    = item_r.timestamp_us - last_edge_r[cmd.ch];
  assign period_c = (|delta[31:16]) ? 16'hFFFF : delta[15:0];
  assign rpm24    = (|quo[31:24]) ? 24'hFFFFFF : quo[23:0];
  assign rpm16    = (|quo[31:16]) ? 16'hFFFF : quo[15:0];
  assign diff     = (rpm24 > win_r[cmd.ch]) ? rpm24 - win_r[cmd.ch] : win_r[cmd.ch] - rpm24;
  assign store_ok = diff < {8'd0, outlier_r};
  assign win_ok   = win_r[cmd.ch] >= {8'd0, min_valid_r};
  assign rd       = store_r[cmd.ch][cmd.idx];
  assign rank_eff = (int'(rank_r) > RING_DEPTH - 1) ? CNT_W'(RING_DEPTH - 1) : CNT_W'(rank_r);
  assign out_free = !out_valid_r || !out_stall;
  assign div_start = cmd.op == DP_DIV_START;

  mpt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r),
    .den   (den_r),
    .quo   (quo),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_period_r <= 16'd100;
      pole_r       <= 7'd7;
      outlier_r    <= 16'd10000;
      min_valid_r  <= 16'd1000;
      windows_r    <= 10'd10;
      rank_r       <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_PERIOD: min_period_r <= cfg_wdata;
        CFG_POLE_PAIRS: pole_r       <= cfg_wdata[6:0];
        CFG_OUTLIER:    outlier_r    <= cfg_wdata;
        CFG_MIN_VALID:  min_valid_r  <= cfg_wdata;
        CFG_WINDOWS:    windows_r    <= cfg_wdata[9:0];
        CFG_RANK:       rank_r       <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // channel state and period rings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        last_edge_r[c] <= '0;
        ring_r[c]      <= '0;
        count_r[c]     <= '0;
        win_r[c]       <= '0;
        for (int k = 0; k < RING_DEPTH; k++) begin
          store_r[c][k] <= '0;
        end
      end
    end else begin
      case (cmd.op)
        DP_EDGE_COMMIT: begin
          last_edge_r[cmd.ch] <= item_r.timestamp_us;
          if (count_r[cmd.ch] != 16'hFFFF) begin
            count_r[cmd.ch] <= count_r[cmd.ch] + 16'd1;
          end
        end
        DP_EDGE_STORE: begin
          if (store_ok) begin
            store_r[cmd.ch][ring_r[cmd.ch]] <= period_r;
            ring_r[cmd.ch] <= (int'(ring_r[cmd.ch]) == RING_DEPTH - 1) ? '0
                                                                         : ring_r[cmd.ch] + 1'b1;
          end
        end
        DP_TICK_STORE: begin
          win_r[cmd.ch]   <= rpm24;
          count_r[cmd.ch] <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD:        item_r <= in_data;
      DP_EDGE_COMMIT: period_r <= period_c;
      DP_EDGE_MUL: begin
        den_r <= DEN_W'(pole_r * period_r);
        num_r <= US_PER_MINUTE;
      end
      DP_TICK_MUL1:   prod_r <= 26'(count_r[cmd.ch] * windows_r);
      DP_TICK_MUL2: begin
        num_r <= NUM_W'(prod_r * 6'd60);
        den_r <= DEN_W'(pole_r);
      end
      DP_RANK_LOAD: begin
        cand_r <= rd;
        less_r <= '0;
      end
      DP_RANK_CMP: begin
        if (rd < cand_r || (rd == cand_r && cmd.idx < cmd.cand)) begin
          less_r <= less_r + 1'b1;
        end
      end
      DP_RANK_PICK: begin
        if (less_r == rank_eff) begin
          sel_r <= cand_r;
        end
      end
      DP_RPT_MUL: begin
        den_r <= DEN_W'(pole_r * sel_r);
        num_r <= US_PER_MINUTE;
      end
      DP_EMIT: begin
        out_r.report_channel <= 2'(cmd.ch);
        out_r.speed_rpm      <= win_ok ? rpm16 : 16'd0;
        out_r.last           <= int'(cmd.ch) == CHANNELS - 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    status.mode     = item_r.mode;
    status.chan     = CH_W'(item_r.channel);
    status.chan_ok  = int'(item_r.channel) < CHANNELS;
    status.edge_ok  = period_c > min_period_r;
    status.win_ok   = win_ok;
    status.rank_hit = less_r == rank_eff;
    status.div_done = div_done;
    status.out_free = out_free;
  end
endmodule

// ----- sv/mpt_ctrl.sv -----
// controller state machine: sequences edge, tick and report transactions
// depends on mpt_pkg; drives the datapath through ctrl_cmd_t
module mpt_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mpt_pkg::dp_status_t status,
  output mpt_pkg::ctrl_cmd_t  cmd
);
  import mpt_pkg::*;

  state_t            state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [RIDX_W-1:0] i_r, i_nxt;
  logic [RIDX_W-1:0] j_r, j_nxt;
  logic              ch_last;
  logic              ring_last_i;
  logic              ring_last_j;

  assign ch_last     = int'(ch_r) == CHANNELS - 1;
  assign ring_last_i = int'(i_r) == RING_DEPTH - 1;
  assign ring_last_j = int'(j_r) == RING_DEPTH - 1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ch_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    in_stall  = 1'b1;
    cmd.op    = DP_NOP;
    cmd.ch    = ch_r;
    cmd.idx   = j_r;
    cmd.cand  = i_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        ch_nxt = '0;
        case (status.mode)
          MODE_EDGE: begin
            ch_nxt    = status.chan;
            state_nxt = status.chan_ok ? S_EDGE_CHK : S_IDLE;
          end
          MODE_TICK:   state_nxt = S_TICK_MUL1;
          MODE_REPORT: state_nxt = S_RPT_START;
          default:     state_nxt = S_IDLE;
        endcase
      end
      S_EDGE_CHK: begin
        if (status.edge_ok) begin
          cmd.op    = DP_EDGE_COMMIT;
          state_nxt = S_EDGE_MUL;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EDGE_MUL: begin
        cmd.op    = DP_EDGE_MUL;
        state_nxt = S_EDGE_GO;
      end
      S_EDGE_GO: begin
        cmd.op    = DP_DIV_START;
        state_nxt = S_EDGE_WAIT;
      end
      S_EDGE_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_EDGE_STORE;
        end
      end
      S_EDGE_STORE: begin
        cmd.op    = DP_EDGE_STORE;
        state_nxt = S_IDLE;
      end
      S_TICK_MUL1: begin
        cmd.op    = DP_TICK_MUL1;
        state_nxt = S_TICK_MUL2;
      end
      S_TICK_MUL2: begin
        cmd.op    = DP_TICK_MUL2;
        state_nxt = S_TICK_GO;
      end
      S_TICK_GO: begin
        cmd.op    = DP_DIV_START;
        state_nxt = S_TICK_WAIT;
      end
      S_TICK_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_TICK_STORE;
        end
      end
      S_TICK_STORE: begin
        cmd.op = DP_TICK_STORE;
        if (ch_last) begin
          state_nxt = S_IDLE;
        end else begin
          ch_nxt    = ch_r + 1'b1;
          state_nxt = S_TICK_MUL1;
        end
      end
      S_RPT_START: begin
        i_nxt     = '0;
        state_nxt = status.win_ok ? S_RANK_LOAD : S_EMIT;
      end
      S_RANK_LOAD: begin
        cmd.op    = DP_RANK_LOAD;
        cmd.idx   = i_r;
        j_nxt     = '0;
        state_nxt = S_RANK_CMP;
      end
      S_RANK_CMP: begin
        cmd.op = DP_RANK_CMP;
        if (ring_last_j) begin
          state_nxt = S_RANK_PICK;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      S_RANK_PICK: begin
        cmd.op = DP_RANK_PICK;
        if (status.rank_hit || ring_last_i) begin
          state_nxt = S_RPT_MUL;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RANK_LOAD;
        end
      end
      S_RPT_MUL: begin
        cmd.op    = DP_RPT_MUL;
        state_nxt = S_RPT_GO;
      end
      S_RPT_GO: begin
        cmd.op    = DP_DIV_START;
        state_nxt = S_RPT_WAIT;
      end
      S_RPT_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.op = DP_EMIT;
          if (ch_last) begin
            state_nxt = S_IDLE;
          end else begin
            ch_nxt    = ch_r + 1'b1;
            state_nxt = S_RPT_START;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ----- sv/multichannel_pulse_tachometer.sv -----
// multichannel pulse tachometer top level: controller plus datapath
// depends on mpt_pkg, mpt_ctrl, mpt_dp, mpt_div
//
// input channel in_valid/in_stall/in_data carries edge, tick and report transactions;
// a transaction is taken when in_valid is high and in_stall low, and in_stall stays
// high until its work is done. output channel out_valid/out_stall/out_data carries
// one result per channel for a report, last set on the highest channel.
// cfg_we/cfg_index/cfg_wdata writes a register; the user must write only while idle, as the block does not enforce it.
// each transaction is sequenced around the bit-serial divider:
//   edge: one divide, skipped when rejected as noise; tick: one divide per channel
//   report: per channel a rank search over the period ring plus one divide,
//   neither for a channel below the minimum window rpm, which reports zero
// one transaction at a time; the output register frees the input side as soon
// as the last result is loaded, so a new transaction may enter while it waits.
// a stalled result holds its data; the controller waits for the register to
// empty before loading the next result of a report.
// reset (synchronous, rst_n low) clears all channel state and period rings to
// zero and reloads register defaults; no clearing pass is needed.
module multichannel_pulse_tachometer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  mpt_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output mpt_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [mpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mpt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mpt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  mpt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status)
  );
endmodule

// ----- sv/mpt_checker.sv -----
// port-level checker for the multichannel pulse tachometer, bound to the top level
// depends on mpt_pkg and multichannel_pulse_tachometer_defines.svh
`include "multichannel_pulse_tachometer_defines.svh"
module mpt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input mpt_pkg::out_item_t out_data
);
  import mpt_pkg::*;

  logic out_held;
  logic last_ch;

  assign out_held = out_valid && out_stall;
  assign last_ch  = out_data.report_channel == 2'(CHANNELS - 1);

  `MPT_ASSERT(a_out_hold, out_held |=> out_valid && $stable(out_data), "stalled result changed")
  `MPT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")
  `MPT_ASSERT(a_last_flag, out_valid |-> (out_data.last == last_ch), "last flag on wrong channel")
  `MPT_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "taken while busy")
endmodule

bind multichannel_pulse_tachometer mpt_checker u_mpt_checker (.*);
